// ===== rtl/core/binary_to_decimal_seven_segment_scan_defines.svh =====
`ifndef BINARY_TO_DECIMAL_SEVEN_SEGMENT_SCAN_DEFINES_SVH
`define BINARY_TO_DECIMAL_SEVEN_SEGMENT_SCAN_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BDSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BDSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bdss_pkg.sv =====
package bdss_pkg;

    localparam int unsigned VALUE_W   = 16;
    localparam int unsigned SELECT_W  = 5;
    localparam int unsigned SEG_W     = 8;
    localparam int unsigned IDX_W     = 3;

    localparam logic [IDX_W-1:0]    IDX_FIRST     = 3'd0;
    localparam logic [IDX_W-1:0]    IDX_LAST      = 3'd4;
    localparam logic [SELECT_W-1:0] SELECT_ONES   = 5'h10;
    localparam logic [SELECT_W-1:0] SELECT_TENS   = 5'h08;
    localparam logic [SELECT_W-1:0] SELECT_HUNDS  = 5'h04;
    localparam logic [SELECT_W-1:0] SELECT_THOUS  = 5'h02;
    localparam logic [SELECT_W-1:0] SELECT_TTHOUS = 5'h01;

    // floor(v / 10) == (v * DIV10_MULT) >> DIV10_SHIFT for every 16-bit v
    localparam logic [VALUE_W-1:0] DIV10_MULT  = 16'hCCCD;
    localparam int unsigned        DIV10_SHIFT = 19;

    typedef struct packed {
        logic [7:0] switch_high;
        logic [7:0] switch_low;
    } src_item_t;

    typedef struct packed {
        logic [SELECT_W-1:0] digit_select;
        logic [SEG_W-1:0]    segments;
        logic                last_digit;
    } dst_item_t;

    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
    } bdss_entry_t;

    function automatic logic [SEG_W-1:0] seg_pattern(input logic [3:0] digit);
        logic [SEG_W-1:0] pat;
        unique case (digit)
            4'd0:    pat = 8'hBF;
            4'd1:    pat = 8'h06;
            4'd2:    pat = 8'h5B;
            4'd3:    pat = 8'h4F;
            4'd4:    pat = 8'h66;
            4'd5:    pat = 8'hED;
            4'd6:    pat = 8'hFD;
            4'd7:    pat = 8'h07;
            4'd8:    pat = 8'hFF;
            4'd9:    pat = 8'hEF;
            default: pat = 8'h00;
        endcase
        return pat;
    endfunction

    function automatic logic [SELECT_W-1:0] digit_select_for(input logic [IDX_W-1:0] idx);
        logic [SELECT_W-1:0] sel;
        unique case (idx)
            3'd0:    sel = SELECT_ONES;
            3'd1:    sel = SELECT_TENS;
            3'd2:    sel = SELECT_HUNDS;
            3'd3:    sel = SELECT_THOUS;
            default: sel = SELECT_TTHOUS;
        endcase
        return sel;
    endfunction

endpackage

// ===== rtl/core/binary_to_decimal_seven_segment_scan.sv =====
// Five-digit decimal scan for a seven-segment display. Each src transaction
// carries a 16-bit value as two switch bytes; the block returns five dst
// transactions, ones digit first, each with a one-hot digit select and that
// digit's segment pattern, the fifth flagged by last_digit. An input byte
// register and a QUEUE_DEPTH-entry queue feed a back end that emits one digit
// per cycle unless dst_stall holds it, dividing by ten with a constant
// multiply, and loads the next value as it emits the last digit. When idle,
// a value passes the input, queue-entry and work registers to the output;
// queued values or a stalled output delay it further. The output register
// lets the next digit be computed while a finished one waits on dst_stall.
`include "binary_to_decimal_seven_segment_scan_defines.svh"

module binary_to_decimal_seven_segment_scan
    import bdss_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      src_valid,
    output logic      src_stall,
    input  src_item_t src_item,
    output logic      dst_valid,
    input  logic      dst_stall,
    output dst_item_t dst_item
);

    bdss_entry_t push;
    logic        push_ready;
    bdss_entry_t head;
    logic        pop;

    bdss_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .src_stall  (src_stall),
        .src_item   (src_item),
        .push       (push),
        .push_ready (push_ready)
    );

    bdss_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .head       (head),
        .pop        (pop)
    );

    bdss_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_item  (dst_item)
    );

    `BDSS_ASSERT_NOW(a_select_onehot, dst_valid, $onehot(dst_item.digit_select),
                     "digit select not one-hot")
    `BDSS_ASSERT_NOW(a_last_matches, dst_valid,
                     dst_item.last_digit == (dst_item.digit_select == SELECT_TTHOUS),
                     "last flag and select disagree")
    `BDSS_ASSERT_NEXT(a_restart_ones, dst_valid && !dst_stall && dst_item.last_digit,
                      !dst_valid || dst_item.digit_select == SELECT_ONES,
                      "new run does not start at ones")
    `BDSS_ASSERT_NOW(a_pop_has_head, pop, head.valid, "pop from empty queue")

endmodule

// ===== rtl/core/bdss_front.sv =====
module bdss_front
    import bdss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        src_valid,
    output logic        src_stall,
    input  src_item_t   src_item,
    output bdss_entry_t push,
    input  logic        push_ready
);

    logic               valid_reg;
    logic               valid_next;
    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;
    logic               accept;

    always_comb
    begin
        src_stall  = valid_reg && !push_ready;
        accept     = src_valid && !src_stall;
        valid_next = valid_reg;
        value_next = value_reg;
        if (accept)
        begin
            valid_next = 1'b1;
            value_next = {src_item.switch_high, src_item.switch_low};
        end
        else if (push_ready)
        begin
            valid_next = 1'b0;
        end
        push.valid = valid_reg;
        push.value = value_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// ===== rtl/core/bdss_queue.sv =====
module bdss_queue
    import bdss_pkg::*;
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  bdss_entry_t push,
    output logic        push_ready,
    output bdss_entry_t head,
    input  logic        pop
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [VALUE_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    always_comb
    begin
        push_ready  = (count_reg != CNT_FULL);
        head.valid  = (count_reg != '0);
        head.value  = entry_reg[rd_ptr_reg];
        do_push     = push.valid && push_ready;
        do_pop      = pop && head.valid;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.value;
        end
    end

endmodule

// ===== rtl/core/bdss_back.sv =====
module bdss_back
    import bdss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  bdss_entry_t head,
    output logic        pop,
    output logic        dst_valid,
    input  logic        dst_stall,
    output dst_item_t   dst_item
);

    logic               work_valid_reg;
    logic               work_valid_next;
    logic [VALUE_W-1:0] work_value_reg;
    logic [VALUE_W-1:0] work_value_next;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    dst_item_t          out_item_reg;
    dst_item_t          out_item_next;
    logic [2*VALUE_W-1:0] product;
    logic [VALUE_W-1:0] quot;
    logic [VALUE_W-1:0] rem_full;
    logic               advance;
    logic               emit;
    logic               finish;

    always_comb
    begin
        product  = {{VALUE_W{1'b0}}, work_value_reg} * {{VALUE_W{1'b0}}, DIV10_MULT};
        quot     = VALUE_W'(product >> DIV10_SHIFT);
        rem_full = work_value_reg - ((quot << 3) + (quot << 1));

        advance = !out_valid_reg || !dst_stall;
        emit    = work_valid_reg && advance;
        finish  = emit && (idx_reg == IDX_LAST);
        pop     = head.valid && (!work_valid_reg || finish);

        work_valid_next = work_valid_reg;
        work_value_next = work_value_reg;
        idx_next        = idx_reg;
        out_item_next   = out_item_reg;
        out_valid_next  = advance ? work_valid_reg : out_valid_reg;

        if (emit)
        begin
            out_item_next.digit_select = digit_select_for(idx_reg);
            out_item_next.segments     = seg_pattern(rem_full[3:0]);
            out_item_next.last_digit   = (idx_reg == IDX_LAST);
            work_value_next            = quot;
            idx_next                   = idx_reg + 1'b1;
            if (finish)
            begin
                work_valid_next = 1'b0;
            end
        end
        if (pop)
        begin
            work_valid_next = 1'b1;
            work_value_next = head.value;
            idx_next        = IDX_FIRST;
        end

        dst_valid = out_valid_reg;
        dst_item  = out_item_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
            idx_reg        <= IDX_FIRST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            work_valid_reg <= work_valid_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_value_reg <= work_value_next;
        out_item_reg   <= out_item_next;
    end

endmodule
